[hdl/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, codes and types of the LSB-first bit stream access core.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int STORE_BYTES     = 4096;
    localparam int MAX_ACCESS_BITS = 64;

    localparam int STORE_BITS = STORE_BYTES * 8;
    localparam int WORD_BITS  = 64;
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int WORDS      = STORE_BITS / WORD_BITS;
    localparam int WIDX_W     = $clog2(WORDS);
    localparam int BANK_DEPTH = WORDS / 2;
    localparam int BANK_AW    = WIDX_W - 1;

    localparam int POS_W   = 16;
    localparam int COUNT_W = 7;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ      = 3'd0,
        MODE_WRITE     = 3'd1,
        MODE_SEEK_ABS  = 3'd2,
        MODE_SEEK_FWD  = 3'd3,
        MODE_SEEK_BACK = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_AT_END  = 2'd1,
        STAT_SHORT   = 2'd2,
        STAT_CLAMPED = 2'd3
    } status_t;

    // access held between the read issue and the merge/write-back cycle
    typedef struct packed {
        logic                 is_write;
        logic                 low_odd;
        logic [OFF_W-1:0]     offset;
        logic [COUNT_W-1:0]   bits;
        logic [WORD_BITS-1:0] wdata;
    } acc_ctx_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] rdata;
        logic [WORD_BITS-1:0] even_wdata;
        logic [WORD_BITS-1:0] odd_wdata;
        logic                 even_touch;
        logic                 odd_touch;
    } merge_res_t;

endpackage

[hdl/bsa_ram.sv]
// ----------------------------------------------------------------------------
// bsa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/bsa_merge.sv]
// ----------------------------------------------------------------------------
// bsa_merge
// Extract and merge logic over the two words that an access spans.
// ----------------------------------------------------------------------------
module bsa_merge
    import bsa_pkg::*;
(
    input  acc_ctx_t             ctx,
    input  logic [WORD_BITS-1:0] even_rdata,
    input  logic [WORD_BITS-1:0] odd_rdata,
    output merge_res_t           res
);

    logic [WORD_BITS-1:0]   lo_word;
    logic [WORD_BITS-1:0]   hi_word;
    logic [2*WORD_BITS-1:0] pair;
    logic [WORD_BITS-1:0]   mask;
    logic [2*WORD_BITS-1:0] mask_sh;
    logic [2*WORD_BITS-1:0] data_sh;
    logic [2*WORD_BITS-1:0] pair_rd;
    logic [2*WORD_BITS-1:0] merged;
    logic                   lo_touch;
    logic                   hi_touch;

    always_comb
    begin
        lo_word = ctx.low_odd ? odd_rdata : even_rdata;
        hi_word = ctx.low_odd ? even_rdata : odd_rdata;
        pair    = {hi_word, lo_word};

        if (32'(ctx.bits) >= WORD_BITS)
        begin
            mask = '1;
        end
        else
        begin
            mask = (WORD_BITS'(1) << ctx.bits) - WORD_BITS'(1);
        end

        mask_sh = {{WORD_BITS{1'b0}}, mask} << ctx.offset;
        data_sh = {{WORD_BITS{1'b0}}, ctx.wdata} << ctx.offset;
        pair_rd = pair >> ctx.offset;
        merged  = (pair & ~mask_sh) | (data_sh & mask_sh);

        lo_touch = |mask_sh[WORD_BITS-1:0];
        hi_touch = |mask_sh[2*WORD_BITS-1:WORD_BITS];

        res.rdata      = pair_rd[WORD_BITS-1:0] & mask;
        res.even_wdata = ctx.low_odd ? merged[2*WORD_BITS-1:WORD_BITS]
                                     : merged[WORD_BITS-1:0];
        res.odd_wdata  = ctx.low_odd ? merged[WORD_BITS-1:0]
                                     : merged[2*WORD_BITS-1:WORD_BITS];
        res.even_touch = ctx.low_odd ? hi_touch : lo_touch;
        res.odd_touch  = ctx.low_odd ? lo_touch : hi_touch;
    end

endmodule

[hdl/bsa_ctrl.sv]
// ----------------------------------------------------------------------------
// bsa_ctrl
// Cursor, length register, item decode, sequencing and result register.
// ----------------------------------------------------------------------------
module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write_en,
    input  logic [POS_W-1:0]     cfg_write_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [COUNT_W-1:0]   bit_count,
    input  logic [WORD_BITS-1:0] write_data,
    input  logic [POS_W-1:0]     seek_amount,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] read_data,
    output logic [STAT_W-1:0]    status,
    output logic [COUNT_W-1:0]   count_out,
    output logic [POS_W-1:0]     position_out,

    output logic                 ram_re,
    output logic [BANK_AW-1:0]   even_raddr,
    output logic [BANK_AW-1:0]   odd_raddr,
    output logic                 even_we,
    output logic                 odd_we,
    output logic [BANK_AW-1:0]   even_waddr,
    output logic [BANK_AW-1:0]   odd_waddr,
    output acc_ctx_t             ctx,
    input  merge_res_t           mres
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_MERGE = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     len_reg;
    logic [POS_W-1:0]     cursor_reg, cursor_next;
    acc_ctx_t             ctx_reg;
    logic [BANK_AW-1:0]   even_addr_reg;
    logic [BANK_AW-1:0]   odd_addr_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [POS_W-1:0]     pos_reg;

    logic                 accept;
    logic                 out_free;
    logic                 merge_fire;
    logic [POS_W-1:0]     len_eff;
    logic [COUNT_W-1:0]   bits_sat;
    logic [POS_W-1:0]     left;
    logic [POS_W-1:0]     rem;
    logic [WIDX_W-1:0]    widx;
    logic [WIDX_W-1:0]    widx_inc;
    logic                 go_merge;
    status_t              stat_new;
    logic [COUNT_W-1:0]   count_new;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE) || !out_free;
    assign accept     = in_valid && !in_stall;
    assign merge_fire = (state_reg == S_MERGE) && out_free;

    always_comb
    begin
        if (32'(len_reg) > STORE_BITS)
        begin
            len_eff = POS_W'(STORE_BITS);
        end
        else
        begin
            len_eff = len_reg;
        end

        if (32'(bit_count) > MAX_ACCESS_BITS)
        begin
            bits_sat = COUNT_W'(MAX_ACCESS_BITS);
        end
        else
        begin
            bits_sat = bit_count;
        end

        left     = len_eff - cursor_reg;
        rem      = (cursor_reg < len_eff) ? left : '0;
        widx     = cursor_reg[OFF_W +: WIDX_W];
        widx_inc = widx + WIDX_W'(1);

        go_merge    = 1'b0;
        stat_new    = STAT_OK;
        count_new   = '0;
        cursor_next = cursor_reg;

        unique case (mode)
            MODE_READ, MODE_WRITE:
            begin
                if (cursor_reg >= len_eff)
                begin
                    stat_new = STAT_AT_END;
                end
                else if (bits_sat != '0)
                begin
                    if (POS_W'(bits_sat) > left)
                    begin
                        stat_new  = STAT_SHORT;
                        count_new = bits_sat - left[COUNT_W-1:0];
                    end
                    else
                    begin
                        go_merge    = 1'b1;
                        count_new   = bits_sat;
                        cursor_next = cursor_reg + POS_W'(bits_sat);
                    end
                end
            end
            MODE_SEEK_ABS:
            begin
                if (seek_amount > len_eff)
                begin
                    cursor_next = len_eff;
                    stat_new    = STAT_CLAMPED;
                end
                else
                begin
                    cursor_next = seek_amount;
                end
            end
            MODE_SEEK_FWD:
            begin
                if (seek_amount > rem)
                begin
                    cursor_next = len_eff;
                    stat_new    = STAT_CLAMPED;
                end
                else
                begin
                    cursor_next = cursor_reg + seek_amount;
                end
            end
            MODE_SEEK_BACK:
            begin
                if (seek_amount > cursor_reg)
                begin
                    cursor_next = '0;
                    stat_new    = STAT_CLAMPED;
                end
                else
                begin
                    cursor_next = cursor_reg - seek_amount;
                end
            end
            default:
            begin
                cursor_next = cursor_reg;
            end
        endcase
    end

    // word w sits in bank w[0]; w+1 sits in the other bank
    assign ram_re     = accept && go_merge;
    assign even_raddr = widx_inc[WIDX_W-1:1];
    assign odd_raddr  = widx[WIDX_W-1:1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && go_merge)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if ((accept && !go_merge) || merge_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                len_reg <= cfg_write_data;
            end
            if (accept)
            begin
                cursor_reg <= cursor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctx_reg.is_write <= (mode == MODE_WRITE);
            ctx_reg.low_odd  <= widx[0];
            ctx_reg.offset   <= cursor_reg[OFF_W-1:0];
            ctx_reg.bits     <= bits_sat;
            ctx_reg.wdata    <= write_data;
            even_addr_reg    <= even_raddr;
            odd_addr_reg     <= odd_raddr;
        end

        if (accept && !go_merge)
        begin
            rdata_reg  <= '0;
            status_reg <= stat_new;
            count_reg  <= count_new;
            pos_reg    <= cursor_next;
        end
        else if (merge_fire)
        begin
            rdata_reg  <= ctx_reg.is_write ? '0 : mres.rdata;
            status_reg <= STAT_OK;
            count_reg  <= ctx_reg.bits;
            pos_reg    <= cursor_reg;
        end
    end

    assign ctx        = ctx_reg;
    assign even_we    = merge_fire && ctx_reg.is_write && mres.even_touch;
    assign odd_we     = merge_fire && ctx_reg.is_write && mres.odd_touch;
    assign even_waddr = even_addr_reg;
    assign odd_waddr  = odd_addr_reg;

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign status       = status_reg;
    assign count_out    = count_reg;
    assign position_out = pos_reg;

endmodule

[hdl/lsb_first_bit_stream_access_core.sv]
// ----------------------------------------------------------------------------
// lsb_first_bit_stream_access_core
// Bit stream store with a bit cursor: LSB-first reads, writes and seeks.
// ----------------------------------------------------------------------------
// A seek, an error, a short-count answer, a zero-bit access or an unused mode
// has its result registered at the edge the item transfers. For a successful
// read or write, the two 64-bit words that the access spans (up to nine bytes)
// are read from an even and an odd word bank at that edge; in the merge state,
// once the result register is free, the extracted or merged words are returned
// and written back. The next item transfers once the previous one has its
// result registered and the result register is free. The store has no reset;
// only bytes that were written may be read.
// ----------------------------------------------------------------------------
module lsb_first_bit_stream_access_core
    import bsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write_en,
    input  logic [POS_W-1:0]     cfg_write_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [COUNT_W-1:0]   bit_count,
    input  logic [WORD_BITS-1:0] write_data,
    input  logic [POS_W-1:0]     seek_amount,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] read_data,
    output logic [STAT_W-1:0]    status,
    output logic [COUNT_W-1:0]   count_out,
    output logic [POS_W-1:0]     position_out
);

    logic                 ram_re;
    logic [BANK_AW-1:0]   even_raddr;
    logic [BANK_AW-1:0]   odd_raddr;
    logic                 even_we;
    logic                 odd_we;
    logic [BANK_AW-1:0]   even_waddr;
    logic [BANK_AW-1:0]   odd_waddr;
    logic [WORD_BITS-1:0] even_rdata;
    logic [WORD_BITS-1:0] odd_rdata;
    acc_ctx_t             ctx;
    merge_res_t           mres;

    bsa_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .bit_count      (bit_count),
        .write_data     (write_data),
        .seek_amount    (seek_amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .status         (status),
        .count_out      (count_out),
        .position_out   (position_out),
        .ram_re         (ram_re),
        .even_raddr     (even_raddr),
        .odd_raddr      (odd_raddr),
        .even_we        (even_we),
        .odd_we         (odd_we),
        .even_waddr     (even_waddr),
        .odd_waddr      (odd_waddr),
        .ctx            (ctx),
        .mres           (mres)
    );

    bsa_merge u_merge (
        .ctx        (ctx),
        .even_rdata (even_rdata),
        .odd_rdata  (odd_rdata),
        .res        (mres)
    );

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (mres.even_wdata),
        .re    (ram_re),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (mres.odd_wdata),
        .re    (ram_re),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

endmodule

[tb/tb_lsb_first_bit_stream_access_core.sv]
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_stream_access_core
// Drives reads, writes and seeks into the bit stream core and checks every
// answer against a bit-level predictor of the store, the cursor and the
// stream length. The store is filled early on, so reads never touch bytes
// that hold no data. Random idle bursts on both channels, none at the end.
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_stream_access_core
    import bsa_pkg::*;
();

    localparam int CLK_HALF       = 6;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int DRAIN_CYCLES   = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic [STAT_W-1:0]    status;
        logic [COUNT_W-1:0]   count;
        logic [POS_W-1:0]     position;
    } access_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [POS_W-1:0]     cfg_write_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [MODE_W-1:0]    mode;
    logic [COUNT_W-1:0]   bit_count;
    logic [WORD_BITS-1:0] write_data;
    logic [POS_W-1:0]     seek_amount;
    logic                 out_valid;
    logic                 out_stall;
    logic [WORD_BITS-1:0] read_data;
    logic [STAT_W-1:0]    status;
    logic [COUNT_W-1:0]   count_out;
    logic [POS_W-1:0]     position_out;

    // predictor state
    bit [STORE_BITS-1:0] stream_img;
    int unsigned         cursor_pos;
    int unsigned         length_reg;

    access_result_t expected_results[$];
    int unsigned    mismatch_count;
    bit             idle_on;

    lsb_first_bit_stream_access_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .bit_count      (bit_count),
        .write_data     (write_data),
        .seek_amount    (seek_amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .status         (status),
        .count_out      (count_out),
        .position_out   (position_out)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int unsigned effective_length();
        return (length_reg < STORE_BITS) ? length_reg : STORE_BITS;
    endfunction

    function automatic access_result_t predict_access(input logic [MODE_W-1:0] m,
                                                      input logic [COUNT_W-1:0] bc,
                                                      input logic [WORD_BITS-1:0] wd,
                                                      input logic [POS_W-1:0] amt);
        access_result_t r;
        int unsigned    avail;
        int unsigned    nbits;
        int unsigned    left;
        int unsigned    rem;
        r        = '0;
        r.status = STAT_OK;
        avail    = effective_length();
        nbits    = (32'(bc) > MAX_ACCESS_BITS) ? MAX_ACCESS_BITS : 32'(bc);
        case (m)
            MODE_READ, MODE_WRITE:
            begin
                if (cursor_pos >= avail)
                    r.status = STAT_AT_END;
                else if (nbits != 0)
                begin
                    left = avail - cursor_pos;
                    if (left < nbits)
                    begin
                        r.status = STAT_SHORT;
                        r.count  = COUNT_W'(nbits - left);
                    end
                    else
                    begin
                        for (int i = 0; i < nbits; i++)
                        begin
                            if (m == MODE_READ)
                                r.read_data[i] = stream_img[cursor_pos + i];
                            else
                                stream_img[cursor_pos + i] = wd[i];
                        end
                        cursor_pos += nbits;
                        r.count = COUNT_W'(nbits);
                    end
                end
            end
            MODE_SEEK_ABS:
            begin
                if (32'(amt) > avail)
                begin
                    cursor_pos = avail;
                    r.status   = STAT_CLAMPED;
                end
                else
                    cursor_pos = 32'(amt);
            end
            MODE_SEEK_FWD:
            begin
                // a cursor left past the end by a shrink has no room ahead
                rem = (cursor_pos < avail) ? avail - cursor_pos : 0;
                if (32'(amt) > rem)
                begin
                    cursor_pos = avail;
                    r.status   = STAT_CLAMPED;
                end
                else
                    cursor_pos += 32'(amt);
            end
            MODE_SEEK_BACK:
            begin
                if (32'(amt) > cursor_pos)
                begin
                    cursor_pos = 0;
                    r.status   = STAT_CLAMPED;
                end
                else
                    cursor_pos -= 32'(amt);
            end
            default:
            begin
            end
        endcase
        r.position = POS_W'(cursor_pos);
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [WORD_BITS-1:0] want,
                                          input logic [WORD_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    endfunction

    // one result per accepted transfer, in order
    always @(posedge clk)
    begin : result_check
        access_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
                note_mismatch("unexpected result", '0, read_data);
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                    note_mismatch("read_data", want.read_data, read_data);
                if (status !== want.status)
                    note_mismatch("status", WORD_BITS'(want.status), WORD_BITS'(status));
                if (count_out !== want.count)
                    note_mismatch("count_out", WORD_BITS'(want.count), WORD_BITS'(count_out));
                if (position_out !== want.position)
                    note_mismatch("position_out", WORD_BITS'(want.position),
                                  WORD_BITS'(position_out));
            end
        end
    end

    initial
    begin : out_stall_gen
        int unsigned n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [COUNT_W-1:0] bc,
                             input logic [WORD_BITS-1:0] wd, input logic [POS_W-1:0] amt);
        in_valid    <= 1'b1;
        mode        <= m;
        bit_count   <= bc;
        write_data  <= wd;
        seek_amount <= amt;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_results.push_back(predict_access(m, bc, wd, amt));
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // length changes only with nothing in flight
    task automatic program_length(input logic [POS_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        length_reg = 32'(value);
    endtask

    function automatic logic [COUNT_W-1:0] pick_bit_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COUNT_W'($urandom_range(MAX_ACCESS_BITS + 1, 127));
            2:       return COUNT_W'(MAX_ACCESS_BITS);
            default: return COUNT_W'($urandom_range(1, MAX_ACCESS_BITS));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_target(input int unsigned avail);
        case ($urandom_range(0, 7))
            0:       return POS_W'($urandom);
            1:       return POS_W'(avail);
            2:       return POS_W'((avail > 70) ? avail - $urandom_range(0, 70)
                                                : $urandom_range(0, avail));
            default: return POS_W'($urandom_range(0, avail));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_distance();
        case ($urandom_range(0, 7))
            0:       return POS_W'($urandom);
            1:       return POS_W'($urandom_range(0, STORE_BITS));
            default: return POS_W'($urandom_range(0, 160));
        endcase
    endfunction

    task automatic send_random_item();
        int unsigned          sel;
        logic [WORD_BITS-1:0] wd;
        logic [COUNT_W-1:0]   junk_count;
        sel        = $urandom_range(0, 99);
        wd         = {$urandom, $urandom};
        junk_count = COUNT_W'($urandom);
        if (sel < 38)
            send_item(MODE_READ, pick_bit_count(), wd, POS_W'($urandom));
        else if (sel < 68)
            send_item(MODE_WRITE, pick_bit_count(), wd, POS_W'($urandom));
        else if (sel < 78)
            send_item(MODE_SEEK_ABS, junk_count, wd, pick_target(effective_length()));
        else if (sel < 87)
            send_item(MODE_SEEK_FWD, junk_count, wd, pick_distance());
        else if (sel < 97)
            send_item(MODE_SEEK_BACK, junk_count, wd, pick_distance());
        else
            send_item(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), junk_count, wd,
                      POS_W'($urandom));
    endtask

    // length zero after reset: nothing to access, every seek pinned at 0
    task automatic test_empty_stream();
        send_item(MODE_READ, 7'd8, '1, '0);
        send_item(MODE_WRITE, 7'd8, '1, '0);
        send_item(MODE_SEEK_ABS, '0, '0, '0);
        send_item(MODE_SEEK_ABS, '0, '0, '1);
        send_item(MODE_SEEK_FWD, '0, '0, 16'd5);
        send_item(MODE_SEEK_BACK, '0, '0, 16'd1);
        send_item(MODE_UNUSED_LO, '1, '1, '1);
    endtask

    task automatic test_fill_store();
        program_length(POS_W'(STORE_BITS));
        send_item(MODE_SEEK_ABS, '0, '0, '0);
        for (int w = 0; w < STORE_BITS / WORD_BITS; w++)
            send_item(MODE_WRITE, COUNT_W'(WORD_BITS), {$urandom, $urandom}, POS_W'($urandom));
    endtask

    task automatic test_access_edges();
        send_item(MODE_SEEK_ABS, '0, '0, '0);
        send_item(MODE_READ, '0, '0, '0);
        send_item(MODE_READ, COUNT_W'(MAX_ACCESS_BITS), '0, '0);
        // bits above bit_count must not land in the store
        send_item(MODE_WRITE, 7'd5, '1, '0);
        send_item(MODE_SEEK_BACK, '0, '0, 16'd69);
        send_item(MODE_READ, '1, '0, '0);
        send_item(MODE_SEEK_ABS, '0, '0, POS_W'(STORE_BITS - 36));
        send_item(MODE_READ, COUNT_W'(MAX_ACCESS_BITS), '0, '0);
        send_item(MODE_READ, 7'd36, '0, '0);
        send_item(MODE_READ, 7'd1, '0, '0);
        send_item(MODE_WRITE, 7'd1, '1, '0);
        send_item(MODE_SEEK_FWD, '0, '0, 16'd1);
        send_item(MODE_SEEK_BACK, '0, '0, 16'd64);
        send_item(MODE_WRITE, COUNT_W'(MAX_ACCESS_BITS), '1, '0);
        send_item(MODE_UNUSED_HI, '0, '0, '0);
    endtask

    // shrink under the cursor, then a length beyond the store
    task automatic test_length_changes();
        program_length(16'd100);
        send_item(MODE_READ, 7'd8, '0, '0);
        send_item(MODE_SEEK_FWD, '0, '0, '0);
        send_item(MODE_SEEK_FWD, '0, '0, 16'd1);
        send_item(MODE_SEEK_BACK, '0, '0, 16'd30);
        send_item(MODE_READ, 7'd40, '0, '0);
        program_length('1);
        send_item(MODE_SEEK_ABS, '0, '0, 16'd40000);
        send_item(MODE_SEEK_BACK, '0, '0, '1);
    endtask

    task automatic test_random_mix();
        logic [POS_W-1:0] lengths [8];
        int unsigned      n;
        lengths = '{POS_W'(STORE_BITS), '1, 16'd130, 16'd1,
                    POS_W'($urandom_range(9, STORE_BITS)), POS_W'(STORE_BITS - 1), '0,
                    POS_W'(STORE_BITS)};
        foreach (lengths[p])
        begin
            if (p == 7)
                idle_on = 1'b0;
            program_length(lengths[p]);
            n = (lengths[p] == 0) ? 20 : 140;
            repeat (n) send_random_item();
        end
    endtask

    initial
    begin : run_limit
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("tb_lsb_first_bit_stream_access_core failed");
        $finish;
    end

    initial
    begin : main_seq
        int unsigned waited;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        mode           = '0;
        bit_count      = '0;
        write_data     = '0;
        seek_amount    = '0;
        stream_img     = '0;
        cursor_pos     = 0;
        length_reg     = 0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stream();
        test_fill_store();
        test_access_edges();
        test_length_changes();
        test_random_mix();

        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_lsb_first_bit_stream_access_core passed");
        else
            $display("tb_lsb_first_bit_stream_access_core failed");
        $finish;
    end

endmodule
